>>> src/dgic_pkg.sv
// shared types and constants for the grid island counter
package dgic_pkg;

  localparam int DEF_MAX_ROWS = 128;
  localparam int DEF_MAX_COLS = 128;
  localparam int SIZE_W = 11;
  localparam int CFG_W = 8;
  localparam int CELL_W = 7;
  localparam int COUNT_W = 14;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CFG_W-1:0] SIZE_RESET = 8'd128;

  typedef enum logic {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_index_t;

  typedef enum logic {
    CMD_MODIFY = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_COUNT,
    OP_CACHED
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CELL_W-1:0] row;
    logic [CELL_W-1:0] col;
    logic              value;
  } cmd_entry_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
  } grid_size_t;

  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_CLEAR,
    BK_SCAN_RD,
    BK_SCAN_CHK,
    BK_POP,
    BK_POP_WAIT,
    BK_NB_RD,
    BK_NB_CHK,
    BK_DONE
  } back_state_t;

endpackage

>>> src/dgic_ram.sv
// generic single-write, single-read ram with registered read data
module dgic_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/dgic_front.sv
// command intake, classification and two-entry queue to the back end
module dgic_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [dgic_pkg::CELL_W-1:0]   in_cell_row,
  input  logic [dgic_pkg::CELL_W-1:0]   in_cell_col,
  input  logic                          in_cell_value,
  input  dgic_pkg::grid_size_t          grid,
  output logic                          q_valid,
  output dgic_pkg::cmd_entry_t          q_entry,
  input  logic                          q_pop
);
  import dgic_pkg::*;

  cmd_entry_t fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       last_q_r, last_q_nxt;
  logic       accept, push, in_range;
  cmd_entry_t entry;

  assign busy    = (count_r == 2'd2);
  assign accept  = start && !busy;
  assign q_valid = (count_r != 2'd0);
  assign q_entry = fifo_r[rd_ptr_r];

  assign in_range = ({{(SIZE_W-CELL_W){1'b0}}, in_cell_row} < grid.rows) &&
                    ({{(SIZE_W-CELL_W){1'b0}}, in_cell_col} < grid.cols);

  always_comb begin
    entry.row   = in_cell_row;
    entry.col   = in_cell_col;
    entry.value = in_cell_value;
    entry.op    = OP_WRITE;
    push        = 1'b0;
    last_q_nxt  = last_q_r;
    if (accept) begin
      if (in_cmd == CMD_QUERY) begin
        entry.op   = last_q_r ? OP_CACHED : OP_COUNT;
        push       = 1'b1;
        last_q_nxt = 1'b1;
      end else begin
        push       = in_range;
        last_q_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      last_q_r <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      last_q_r <= last_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= entry;
    end
  end

endmodule

>>> src/dgic_back.sv
// back end: cell writes, seen-map clearing, raster scan and stack flood fill
module dgic_back #(
  parameter int MAX_ROWS = dgic_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = dgic_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dgic_pkg::grid_size_t          grid,
  input  logic                          q_valid,
  input  dgic_pkg::cmd_entry_t          q_entry,
  output logic                          q_pop,
  output logic                          out_valid,
  output logic [dgic_pkg::COUNT_W-1:0]  out_island_count
);
  import dgic_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [AW:0] STACK_FULL = (AW+1)'(DEPTH);

  back_state_t state_r, state_nxt;

  logic [SIZE_W-1:0]  scan_row_r, scan_row_nxt;
  logic [SIZE_W-1:0]  scan_col_r, scan_col_nxt;
  logic [SIZE_W-1:0]  cur_row_r, cur_row_nxt;
  logic [SIZE_W-1:0]  cur_col_r, cur_col_nxt;
  logic [1:0]         nb_k_r, nb_k_nxt;
  logic [AW-1:0]      nb_addr_r, nb_addr_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [AW:0]        top_r, top_nxt;
  logic [COUNT_W-1:0] tally_r, tally_nxt;
  logic [COUNT_W-1:0] cached_r, cached_nxt;

  logic [AW-1:0] rd_addr, scan_addr, nb_addr;
  logic          land_we, land_wdata, land_rdata;
  logic [AW-1:0] land_waddr;
  logic          seen_we, seen_wdata, seen_rdata;
  logic [AW-1:0] seen_waddr;
  logic          stk_we;
  logic [AW-1:0] stk_waddr, stk_raddr, stk_rdata;

  logic [SIZE_W-1:0] nb_row, nb_col;
  logic              nb_ok, scan_last, grid_empty, fresh_cell;

  function automatic logic [AW-1:0] rd_addr_q();
    return (state_r == BK_NB_CHK) ? nb_addr_r : scan_addr;
  endfunction

  assign scan_addr  = {RW'(scan_row_r), CW'(scan_col_r)};
  assign scan_last  = ((scan_row_r + 1'b1) >= grid.rows) &&
                      ((scan_col_r + 1'b1) >= grid.cols);
  assign grid_empty = (grid.rows == '0) || (grid.cols == '0);
  assign fresh_cell = land_rdata && !seen_rdata;
  assign nb_addr    = {RW'(nb_row), CW'(nb_col)};

  always_comb begin
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    nb_ok  = 1'b0;
    case (nb_k_r)
      2'd0: begin
        nb_row = cur_row_r + 1'b1;
        nb_ok  = (cur_row_r + 1'b1) < grid.rows;
      end
      2'd1: begin
        nb_row = cur_row_r - 1'b1;
        nb_ok  = (cur_row_r != '0);
      end
      2'd2: begin
        nb_col = cur_col_r + 1'b1;
        nb_ok  = (cur_col_r + 1'b1) < grid.cols;
      end
      default: begin
        nb_col = cur_col_r - 1'b1;
        nb_ok  = (cur_col_r != '0);
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_INIT:     state_nxt = (clr_addr_r == '1) ? BK_IDLE : BK_INIT;
      BK_IDLE: begin
        if (q_valid) begin
          case (q_entry.op)
            OP_COUNT: state_nxt = grid_empty ? BK_DONE : BK_CLEAR;
            default:  state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_CLEAR:    state_nxt = (clr_addr_r == '1) ? BK_SCAN_RD : BK_CLEAR;
      BK_SCAN_RD:  state_nxt = BK_SCAN_CHK;
      BK_SCAN_CHK: begin
        if (fresh_cell) begin
          state_nxt = BK_POP;
        end else begin
          state_nxt = scan_last ? BK_DONE : BK_SCAN_RD;
        end
      end
      BK_POP: begin
        if (top_r == '0) begin
          state_nxt = scan_last ? BK_DONE : BK_SCAN_RD;
        end else begin
          state_nxt = BK_POP_WAIT;
        end
      end
      BK_POP_WAIT: state_nxt = BK_NB_RD;
      BK_NB_RD:    state_nxt = nb_ok ? BK_NB_CHK : ((nb_k_r == 2'd3) ? BK_POP : BK_NB_RD);
      BK_NB_CHK:   state_nxt = (nb_k_r == 2'd3) ? BK_POP : BK_NB_RD;
      BK_DONE:     state_nxt = BK_IDLE;
      default:     state_nxt = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    scan_row_nxt     = scan_row_r;
    scan_col_nxt     = scan_col_r;
    cur_row_nxt      = cur_row_r;
    cur_col_nxt      = cur_col_r;
    nb_k_nxt         = nb_k_r;
    nb_addr_nxt      = nb_addr_r;
    clr_addr_nxt     = clr_addr_r;
    top_nxt          = top_r;
    tally_nxt        = tally_r;
    cached_nxt       = cached_r;
    q_pop            = 1'b0;
    out_valid        = 1'b0;
    out_island_count = cached_r;
    rd_addr          = scan_addr;
    land_we          = 1'b0;
    land_waddr       = {RW'(q_entry.row), CW'(q_entry.col)};
    land_wdata       = q_entry.value;
    seen_we          = 1'b0;
    seen_waddr       = scan_addr;
    seen_wdata       = 1'b1;
    stk_we           = 1'b0;
    stk_waddr        = top_r[AW-1:0];
    stk_raddr        = top_r[AW-1:0] - 1'b1;
    case (state_r)
      BK_INIT: begin
        land_we      = 1'b1;
        land_waddr   = clr_addr_r;
        land_wdata   = 1'b0;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_entry.op)
            OP_WRITE: land_we = 1'b1;
            OP_CACHED: out_valid = 1'b1;
            default: begin
              tally_nxt    = '0;
              clr_addr_nxt = '0;
            end
          endcase
        end
      end
      BK_CLEAR: begin
        seen_we      = 1'b1;
        seen_waddr   = clr_addr_r;
        seen_wdata   = 1'b0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        scan_row_nxt = '0;
        scan_col_nxt = '0;
      end
      BK_SCAN_CHK: begin
        if (fresh_cell) begin
          seen_we = 1'b1;
          stk_we  = 1'b1;
          top_nxt = (AW+1)'(1);
        end else if (!scan_last) begin
          if ((scan_col_r + 1'b1) < grid.cols) begin
            scan_col_nxt = scan_col_r + 1'b1;
          end else begin
            scan_col_nxt = '0;
            scan_row_nxt = scan_row_r + 1'b1;
          end
        end
      end
      BK_POP: begin
        if (top_r == '0) begin
          if (tally_r != COUNT_MAX) begin
            tally_nxt = tally_r + 1'b1;
          end
          if (!scan_last) begin
            if ((scan_col_r + 1'b1) < grid.cols) begin
              scan_col_nxt = scan_col_r + 1'b1;
            end else begin
              scan_col_nxt = '0;
              scan_row_nxt = scan_row_r + 1'b1;
            end
          end
        end else begin
          top_nxt = top_r - 1'b1;
        end
      end
      BK_POP_WAIT: begin
        cur_row_nxt = SIZE_W'(stk_rdata[AW-1:CW]);
        cur_col_nxt = SIZE_W'(stk_rdata[CW-1:0]);
        nb_k_nxt    = 2'd0;
      end
      BK_NB_RD: begin
        rd_addr     = nb_addr;
        nb_addr_nxt = nb_addr;
        if (!nb_ok) begin
          nb_k_nxt = nb_k_r + 1'b1;
        end
      end
      BK_NB_CHK: begin
        seen_waddr = nb_addr_r;
        stk_waddr  = top_r[AW-1:0];
        if (fresh_cell) begin
          seen_we = 1'b1;
          stk_we  = 1'b1;
          top_nxt = top_r + 1'b1;
        end
        nb_k_nxt = nb_k_r + 1'b1;
      end
      BK_DONE: begin
        out_valid        = 1'b1;
        out_island_count = tally_r;
        cached_nxt       = tally_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_INIT;
      top_r      <= '0;
      tally_r    <= '0;
      cached_r   <= '0;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      top_r      <= top_nxt;
      tally_r    <= tally_nxt;
      cached_r   <= cached_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_row_r <= scan_row_nxt;
    scan_col_r <= scan_col_nxt;
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    nb_k_r     <= nb_k_nxt;
    nb_addr_r  <= nb_addr_nxt;
  end

  dgic_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_land (
    .clk(clk), .we(land_we), .waddr(land_waddr), .wdata(land_wdata),
    .raddr(rd_addr), .rdata(land_rdata)
  );

  dgic_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_seen (
    .clk(clk), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
    .raddr(rd_addr), .rdata(seen_rdata)
  );

  dgic_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(rd_addr_q()),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= STACK_FULL) else $error("stack overran");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == BK_DONE) || (state_r == BK_IDLE && q_pop))
    else $error("result outside done or cached pop");
  a_land_idle: assert property (@(posedge clk) disable iff (!rst_n)
    land_we |-> (state_r == BK_IDLE) || (state_r == BK_INIT))
    else $error("land write during a count");
  a_done_cache: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DONE) |=> (cached_r == $past(tally_r)))
    else $error("cached count not updated");
`endif

endmodule

>>> src/dynamic_grid_island_count.sv
// top level of the grid island counter
//
// usage: a transaction enters when start is high and busy is low. in_cmd
// selects a cell modify (in_cell_row, in_cell_col, in_cell_value) or a
// region count query. a modify gives no result; a query gives one result,
// out_island_count, shown for one cycle with out_valid. results cannot be
// held off by the receiver.
// the size registers (index 0 rows, index 1 cols) are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write them only
// while the block is idle, and the block itself does not enforce this.
// a two-entry queue sits between intake and the counting engine, so busy
// rises only when two transactions are waiting.
// a modify writes one land cell in the engine. a fresh query clears every
// entry of the seen map (2^(row bits + col bits), 16384 for 128x128), then
// scans the cells in use in raster order and flood fills each new land
// region from a stack. a repeated query answers with the cached count.
// reset: sizes 128, cached count 0; then a pass writes every one of the
// 2^(row bits + col bits) cells to water while transactions wait in the queue.
module dynamic_grid_island_count #(
  parameter int MAX_ROWS = dgic_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = dgic_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [dgic_pkg::CELL_W-1:0]   in_cell_row,
  input  logic [dgic_pkg::CELL_W-1:0]   in_cell_col,
  input  logic                          in_cell_value,
  output logic                          out_valid,
  output logic [dgic_pkg::COUNT_W-1:0]  out_island_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [dgic_pkg::CFG_W-1:0]    cfg_data
);
  import dgic_pkg::*;

  localparam logic [SIZE_W-1:0] ROWS_LIM = SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] COLS_LIM = SIZE_W'(MAX_COLS);

  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [CFG_W-1:0] cols_r, cols_nxt;
  logic [SIZE_W-1:0] rows_ext, cols_ext;
  grid_size_t grid;
  logic       q_valid, q_pop;
  cmd_entry_t q_entry;

  assign cfg_ready = 1'b1;

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS: rows_nxt = cfg_data;
        default:  cols_nxt = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIZE_RESET;
      cols_r <= SIZE_RESET;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  assign rows_ext  = SIZE_W'(rows_r);
  assign cols_ext  = SIZE_W'(cols_r);
  assign grid.rows = (rows_ext > ROWS_LIM) ? ROWS_LIM : rows_ext;
  assign grid.cols = (cols_ext > COLS_LIM) ? COLS_LIM : cols_ext;

  dgic_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_cell_row(in_cell_row), .in_cell_col(in_cell_col),
    .in_cell_value(in_cell_value), .grid(grid),
    .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop)
  );

  dgic_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk(clk), .rst_n(rst_n), .grid(grid),
    .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop),
    .out_valid(out_valid), .out_island_count(out_island_count)
  );

endmodule
